[src/bcls_pkg.sv]
// Shared types and constants for the button click level selector.
// No dependencies; imported by every design module of the block, not by the checker.
package bcls_pkg;

    // Register indexes on the configuration port
    localparam logic [2:0] CFG_DEBOUNCE    = 3'd0;
    localparam logic [2:0] CFG_MIN_PRESS   = 3'd1;
    localparam logic [2:0] CFG_SINGLE_WAIT = 3'd2;
    localparam logic [2:0] CFG_MULTI_GAP   = 3'd3;
    localparam logic [2:0] CFG_MAX_LEVEL   = 3'd4;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 12;
    localparam int LEVEL_W     = 4;
    localparam int COUNT_W     = 2;

    // Register values after reset
    localparam logic [7:0]  RST_DEBOUNCE    = 8'd20;
    localparam logic [9:0]  RST_MIN_PRESS   = 10'd30;
    localparam logic [11:0] RST_SINGLE_WAIT = 12'd300;
    localparam logic [11:0] RST_MULTI_GAP   = 12'd800;
    localparam logic [3:0]  RST_MAX_LEVEL   = 4'd6;

    // Click counts of interest
    localparam logic [COUNT_W-1:0] CNT_NONE   = 2'd0;
    localparam logic [COUNT_W-1:0] CNT_SINGLE = 2'd1;
    localparam logic [COUNT_W-1:0] CNT_DOUBLE = 2'd2;

    // Pin levels of the active-low down button
    localparam logic PIN_PRESSED  = 1'b0;
    localparam logic PIN_RELEASED = 1'b1;

    typedef struct packed {
        logic [7:0]  debounce_ticks;
        logic [9:0]  min_press_ticks;
        logic [11:0] single_wait_ticks;
        logic [11:0] multi_gap_ticks;
        logic [3:0]  max_level;
    } cfg_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] level_out;
        logic               emergency_cmd;
        logic               down_cmd;
        logic               up_cmd;
    } result_t;

endpackage

[src/bcls_cfg_regs.sv]
// Configuration register file for the button click level selector.
// Depends on bcls_pkg for register indexes, reset values and cfg_t.
module bcls_cfg_regs
    import bcls_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   wr_en,
    input  logic [CFG_INDEX_W-1:0] wr_index,
    input  logic [CFG_DATA_W-1:0]  wr_data,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;

    // Write one register per accepted word; unknown indexes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ticks    <= RST_DEBOUNCE;
            cfg_reg.min_press_ticks   <= RST_MIN_PRESS;
            cfg_reg.single_wait_ticks <= RST_SINGLE_WAIT;
            cfg_reg.multi_gap_ticks   <= RST_MULTI_GAP;
            cfg_reg.max_level         <= RST_MAX_LEVEL;
        end
        else if (wr_en)
        begin
            case (wr_index)
                CFG_DEBOUNCE:    cfg_reg.debounce_ticks    <= wr_data[7:0];
                CFG_MIN_PRESS:   cfg_reg.min_press_ticks   <= wr_data[9:0];
                CFG_SINGLE_WAIT: cfg_reg.single_wait_ticks <= wr_data[11:0];
                CFG_MULTI_GAP:   cfg_reg.multi_gap_ticks   <= wr_data[11:0];
                CFG_MAX_LEVEL:   cfg_reg.max_level         <= wr_data[3:0];
                default:         ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

[src/bcls_tick_core.sv]
// Per-tick state and update logic: debounce, press timing, click counting, level.
// Depends on bcls_pkg for cfg_t, result_t and constants.
module bcls_tick_core
    import bcls_pkg::*;
#(
    parameter int TIMER_BITS = 16
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    step,
    input  logic    raw_level,
    input  logic    up_click,
    input  cfg_t    cfg,
    output result_t result
);

    localparam logic [TIMER_BITS-1:0] TMAX = {TIMER_BITS{1'b1}};
    localparam logic [TIMER_BITS-1:0] ONE  = TIMER_BITS'(1);

    logic                  raw_prev_reg, raw_prev_next;
    logic                  stable_reg, stable_next;
    logic [TIMER_BITS-1:0] since_change_reg, since_change_next;
    logic [TIMER_BITS-1:0] press_ticks_reg, press_ticks_next;
    logic                  press_active_reg, press_active_next;
    logic                  press_used_reg, press_used_next;
    logic [TIMER_BITS-1:0] since_click_reg, since_click_next;
    logic                  click_seen_reg, click_seen_next;
    logic [COUNT_W-1:0]    click_count_reg, click_count_next;
    logic [LEVEL_W-1:0]    level_reg, level_next;
    logic                  up_cmd, down_cmd, emg_cmd;

    // Next state for one tick
    always_comb
    begin
        up_cmd   = 1'b0;
        down_cmd = 1'b0;
        emg_cmd  = 1'b0;

        press_active_next = press_active_reg;
        press_used_next   = press_used_reg;
        click_seen_next   = click_seen_reg;
        click_count_next  = click_count_reg;
        stable_next       = stable_reg;
        raw_prev_next     = raw_level;
        level_next        = level_reg;

        // Up click raises the level below the ceiling
        if (up_click && (level_reg < cfg.max_level))
        begin
            level_next = level_reg + LEVEL_W'(1);
            up_cmd     = 1'b1;
        end

        // Saturating time counters
        since_change_next = (since_change_reg == TMAX) ? TMAX : since_change_reg + ONE;
        press_ticks_next  = (press_ticks_reg == TMAX) ? TMAX : press_ticks_reg + ONE;
        since_click_next  = (since_click_reg == TMAX) ? TMAX : since_click_reg + ONE;
        if (raw_level != raw_prev_reg)
        begin
            since_change_next = '0;
        end

        // Debounced edge of the down button
        if ((since_change_next >= TIMER_BITS'(cfg.debounce_ticks)) &&
            (raw_level != stable_reg))
        begin
            stable_next = raw_level;
            if (raw_level == PIN_PRESSED)
            begin
                press_ticks_next  = '0;
                press_active_next = 1'b1;
                press_used_next   = 1'b0;
            end
            else if (press_active_reg)
            begin
                press_active_next = 1'b0;
                if ((press_ticks_next >= TIMER_BITS'(cfg.min_press_ticks)) &&
                    !press_used_reg)
                begin
                    press_used_next = 1'b1;
                    if (click_seen_reg &&
                        (since_click_next <= TIMER_BITS'(cfg.multi_gap_ticks)))
                    begin
                        click_count_next = click_count_reg + COUNT_W'(1);
                    end
                    else
                    begin
                        click_count_next = CNT_SINGLE;
                    end
                    since_click_next = '0;
                    click_seen_next  = 1'b1;
                    if (click_count_next >= CNT_DOUBLE)
                    begin
                        level_next       = '0;
                        emg_cmd          = 1'b1;
                        click_count_next = CNT_NONE;
                    end
                end
            end
        end

        // A lone click resolves once the single-click wait has passed
        if ((click_count_next == CNT_SINGLE) &&
            (since_click_next > TIMER_BITS'(cfg.single_wait_ticks)))
        begin
            if (level_next != '0)
            begin
                level_next = level_next - LEVEL_W'(1);
            end
            down_cmd         = 1'b1;
            click_count_next = CNT_NONE;
        end
    end

    // State registers advance once per tick word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_prev_reg     <= PIN_RELEASED;
            stable_reg       <= PIN_RELEASED;
            since_change_reg <= '0;
            press_ticks_reg  <= '0;
            press_active_reg <= 1'b0;
            press_used_reg   <= 1'b0;
            since_click_reg  <= '0;
            click_seen_reg   <= 1'b0;
            click_count_reg  <= CNT_NONE;
            level_reg        <= '0;
        end
        else if (step)
        begin
            raw_prev_reg     <= raw_prev_next;
            stable_reg       <= stable_next;
            since_change_reg <= since_change_next;
            press_ticks_reg  <= press_ticks_next;
            press_active_reg <= press_active_next;
            press_used_reg   <= press_used_next;
            since_click_reg  <= since_click_next;
            click_seen_reg   <= click_seen_next;
            click_count_reg  <= click_count_next;
            level_reg        <= level_next;
        end
    end

    assign result.up_cmd        = up_cmd;
    assign result.down_cmd      = down_cmd;
    assign result.emergency_cmd = emg_cmd;
    assign result.level_out     = level_next;

endmodule

[src/button_click_level_selector.sv]
// Top level of the button click level selector: input register, tick core, result register.
// Depends on bcls_pkg, bcls_cfg_regs and bcls_tick_core.
//
// Usage: each word on the s_axis channel is one tick carrying the raw active-low
// down-button pin and an up-click pulse. For every accepted word exactly one
// result word leaves on m_axis with the up, down and emergency flags and the
// level after that tick.
// The cfg channel writes one register per word (index, data); it is always
// ready; the user must use it only while the block is idle, which it does not enforce.
// An accepted input word is held in the input register, then passes through the tick
// logic into the result register. Throughput is one word per cycle while the receiver
// does not stall; the per-tick state update is a single pass of counter increments and
// compares between those two registers.
// Reset clears the configuration to its defaults, the level to zero, the
// debouncer to released and both pipeline registers to empty.
// When the receiver stalls the result word holds; the input register still
// takes one more word if it is empty, and then s_axis_tready drops until the result is taken.
module button_click_level_selector
    import bcls_pkg::*;
#(
    parameter int TIMER_BITS = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [7:0]             s_axis_tdata,  // [0] raw_level, [1] up_click, rest zero
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [7:0]             m_axis_tdata,  // [0] up_cmd, [1] down_cmd,
                                                  // [2] emergency_cmd, [6:3] level_out
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t    cfg;
    result_t result;

    logic    in_valid_reg;
    logic    in_raw_reg;
    logic    in_up_reg;
    logic    out_valid_reg;
    result_t out_data_reg;
    logic    advance;
    logic    in_load;

    // Configuration registers
    assign cfg_ready = 1'b1;

    bcls_cfg_regs u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // Pipeline control: the tick moves on when the result register is free
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_load       = s_axis_tvalid && s_axis_tready;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            in_raw_reg <= s_axis_tdata[0];
            in_up_reg  <= s_axis_tdata[1];
        end
    end

    // Tick logic and state
    bcls_tick_core #(
        .TIMER_BITS (TIMER_BITS)
    ) u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .raw_level (in_raw_reg),
        .up_click  (in_up_reg),
        .cfg       (cfg),
        .result    (result)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_data_reg};

endmodule

[src/bcls_checker.sv]
// Port-level checks for the button click level selector, bound to the top level.
// Depends on bcls_pkg only through the bound module's port widths.
module bcls_checker
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    input  logic       s_axis_tready,
    input  logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    input  logic [7:0] m_axis_tdata
);

    // An emergency word always reports a zero level.
    a_emg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[2]) |-> (m_axis_tdata[6:3] == 4'd0))
        else $error("emergency word with nonzero level");

    // A down and an emergency command never resolve in the same tick.
    a_down_emg: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[1] && m_axis_tdata[2]))
        else $error("down and emergency in one word");

    // An up command that did not coincide with an emergency or a down command leaves a nonzero level.
    a_up_level: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[0] && !m_axis_tdata[2] && !m_axis_tdata[1])
        |-> (m_axis_tdata[6:3] != 4'd0))
        else $error("up command with zero level");

    // A stalled result word holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result word changed");

    // Once the result side has drained, a new result needs an input word accepted
    // at the edge where it drained or later; none was accepted at that edge here.
    a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
        ($fell(m_axis_tvalid) && !$past(s_axis_tvalid && s_axis_tready)) |=> !m_axis_tvalid)
        else $error("result word without input word");

endmodule

bind button_click_level_selector bcls_checker u_bcls_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
